// File: rtl/epbcd_pkg.sv
// Shared types, phase codes, constants and helper functions for the epoch-to-BCD converter.
package epbcd_pkg;

  // Controller phase codes, also decoded by the datapath.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_YEAR  = 4'd1;
  localparam logic [3:0] PH_MONTH = 4'd2;
  localparam logic [3:0] PH_DAY_T = 4'd3;
  localparam logic [3:0] PH_DAY_O = 4'd4;
  localparam logic [3:0] PH_HR_T  = 4'd5;
  localparam logic [3:0] PH_HR_O  = 4'd6;
  localparam logic [3:0] PH_MIN_T = 4'd7;
  localparam logic [3:0] PH_MIN_O = 4'd8;
  localparam logic [3:0] PH_SEC_T = 4'd9;
  localparam logic [3:0] PH_FIN   = 4'd10;

  localparam logic [31:0] DAY_SECS         = 32'd86400;
  localparam logic [31:0] TEN_DAY_SECS     = 32'd864000;
  localparam logic [31:0] LEAP_YEAR_SECS   = 32'd31622400;
  localparam logic [31:0] COMMON_YEAR_SECS = 32'd31536000;
  localparam logic [31:0] TEN_HOUR_SECS    = 32'd36000;
  localparam logic [31:0] HOUR_SECS        = 32'd3600;
  localparam logic [31:0] TEN_MINUTE_SECS  = 32'd600;
  localparam logic [31:0] MINUTE_SECS      = 32'd60;
  localparam logic [31:0] TEN_SECS         = 32'd10;

  // Epoch year 1970 as BCD century and year within century.
  localparam logic [5:0] EPOCH_CENT_BCD = 6'h19;
  localparam logic [7:0] EPOCH_YY_BCD   = 8'h70;
  localparam logic [5:0] LEAP_CENT_BCD  = 6'h20;

  typedef struct packed {
    logic       start;
    logic       load;
    logic [3:0] phase;
  } cmd_t;

  typedef struct packed {
    logic ge;
  } status_t;

  // Length of a common-year month in seconds, month numbered 1 to 12.
  function automatic logic [31:0] month_secs(input logic [3:0] mon);
    logic [31:0] len;
    case (mon)
      4'd2:                      len = 32'd2419200;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 32'd2592000;
      default:                   len = 32'd2678400;
    endcase
    return len;
  endfunction

  // Two-digit BCD increment, wrapping 99 to 00.
  function automatic logic [7:0] bcd2_inc(input logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] == 4'd9) begin
      r[3:0] = 4'd0;
      r[7:4] = (v[7:4] == 4'd9) ? 4'd0 : v[7:4] + 4'd1;
    end else begin
      r = {v[7:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

endpackage

// File: rtl/epbcd_ctrl.sv
// Phase sequencer and output handshake control for the epoch-to-BCD converter.
module epbcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  epbcd_pkg::status_t  status,
  output epbcd_pkg::cmd_t     cmd
);

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       start, load;

  assign start = (state_r == epbcd_pkg::PH_IDLE) && in_valid;
  assign load  = (state_r == epbcd_pkg::PH_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      epbcd_pkg::PH_IDLE: begin
        if (in_valid) state_nxt = epbcd_pkg::PH_YEAR;
      end
      epbcd_pkg::PH_YEAR, epbcd_pkg::PH_MONTH, epbcd_pkg::PH_DAY_T,
      epbcd_pkg::PH_DAY_O, epbcd_pkg::PH_HR_T, epbcd_pkg::PH_HR_O,
      epbcd_pkg::PH_MIN_T, epbcd_pkg::PH_MIN_O, epbcd_pkg::PH_SEC_T: begin
        // Stay while the current unit still fits in the remainder.
        if (!status.ge) state_nxt = state_r + 4'd1;
      end
      epbcd_pkg::PH_FIN: begin
        if (load) state_nxt = epbcd_pkg::PH_IDLE;
      end
      default: state_nxt = epbcd_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= epbcd_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != epbcd_pkg::PH_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.start = start;
  assign cmd.load  = load;
  assign cmd.phase = state_r;

endmodule

// File: rtl/epbcd_dp.sv
// Remainder register, subtract-and-compare unit, BCD counters and output registers.
module epbcd_dp (
  input  logic                clk,
  input  logic [31:0]         in_epoch_seconds,
  input  epbcd_pkg::cmd_t     cmd,
  output epbcd_pkg::status_t  status,
  output logic [5:0]          out_century_bcd,
  output logic [7:0]          out_year_bcd,
  output logic [4:0]          out_month_bcd,
  output logic [5:0]          out_day_bcd,
  output logic [5:0]          out_hour_bcd,
  output logic [6:0]          out_minute_bcd,
  output logic [6:0]          out_second_bcd
);

  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  cent_r, cent_nxt;
  logic [7:0]  yy_r, yy_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic [5:0]  day_r, day_nxt;
  logic [5:0]  hour_r, hour_nxt;
  logic [6:0]  min_r, min_nxt;
  logic [6:0]  sec_r, sec_nxt;

  logic [5:0]  o_cent_r;
  logic [7:0]  o_yy_r;
  logic [4:0]  o_mon_r;
  logic [5:0]  o_day_r;
  logic [5:0]  o_hour_r;
  logic [6:0]  o_min_r;
  logic [6:0]  o_sec_r;

  logic        div4, leap, ge;
  logic [31:0] sub, diff;
  logic [7:0]  yy_inc, cent_inc;
  logic [3:0]  mon_lo;
  logic [4:0]  mon_bcd;

  // Leap test straight from the BCD digits: multiple of four by tens parity
  // and ones digit; a century year is leap only for 2000.
  always_comb begin
    if (!yy_r[4]) begin
      div4 = (yy_r[3:0] == 4'd0) || (yy_r[3:0] == 4'd4) || (yy_r[3:0] == 4'd8);
    end else begin
      div4 = (yy_r[3:0] == 4'd2) || (yy_r[3:0] == 4'd6);
    end
    if (yy_r == 8'h00) begin
      leap = (cent_r == epbcd_pkg::LEAP_CENT_BCD);
    end else begin
      leap = div4;
    end
  end

  always_comb begin
    case (cmd.phase)
      epbcd_pkg::PH_YEAR:
        sub = leap ? epbcd_pkg::LEAP_YEAR_SECS : epbcd_pkg::COMMON_YEAR_SECS;
      epbcd_pkg::PH_MONTH:
        sub = epbcd_pkg::month_secs(mon_r)
              + ((leap && mon_r == 4'd2) ? epbcd_pkg::DAY_SECS : 32'd0);
      epbcd_pkg::PH_DAY_T: sub = epbcd_pkg::TEN_DAY_SECS;
      epbcd_pkg::PH_DAY_O: sub = epbcd_pkg::DAY_SECS;
      epbcd_pkg::PH_HR_T:  sub = epbcd_pkg::TEN_HOUR_SECS;
      epbcd_pkg::PH_HR_O:  sub = epbcd_pkg::HOUR_SECS;
      epbcd_pkg::PH_MIN_T: sub = epbcd_pkg::TEN_MINUTE_SECS;
      epbcd_pkg::PH_MIN_O: sub = epbcd_pkg::MINUTE_SECS;
      epbcd_pkg::PH_SEC_T: sub = epbcd_pkg::TEN_SECS;
      default:             sub = epbcd_pkg::TEN_SECS;
    endcase
  end

  assign ge        = (rem_r >= sub);
  assign diff      = rem_r - sub;
  assign status.ge = ge;
  assign yy_inc    = epbcd_pkg::bcd2_inc(yy_r);
  assign cent_inc  = epbcd_pkg::bcd2_inc({2'b00, cent_r});

  always_comb begin
    rem_nxt  = rem_r;
    cent_nxt = cent_r;
    yy_nxt   = yy_r;
    mon_nxt  = mon_r;
    day_nxt  = day_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    sec_nxt  = sec_r;
    if (cmd.start) begin
      rem_nxt  = in_epoch_seconds;
      cent_nxt = epbcd_pkg::EPOCH_CENT_BCD;
      yy_nxt   = epbcd_pkg::EPOCH_YY_BCD;
      mon_nxt  = 4'd1;
      day_nxt  = 6'h00;
      hour_nxt = 6'h00;
      min_nxt  = 7'h00;
      sec_nxt  = 7'h00;
    end else begin
      case (cmd.phase)
        epbcd_pkg::PH_YEAR: begin
          if (ge) begin
            rem_nxt = diff;
            yy_nxt  = yy_inc;
            if (yy_r == 8'h99) cent_nxt = cent_inc[5:0];
          end
        end
        epbcd_pkg::PH_MONTH: begin
          if (ge) begin
            rem_nxt = diff;
            mon_nxt = mon_r + 4'd1;
          end else begin
            // One extra day makes the day count come out one-based.
            rem_nxt = rem_r + epbcd_pkg::DAY_SECS;
          end
        end
        epbcd_pkg::PH_DAY_T: begin
          if (ge) begin
            rem_nxt = diff;
            day_nxt = day_r + 6'h10;
          end
        end
        epbcd_pkg::PH_DAY_O: begin
          if (ge) begin
            rem_nxt = diff;
            day_nxt = day_r + 6'h01;
          end
        end
        epbcd_pkg::PH_HR_T: begin
          if (ge) begin
            rem_nxt  = diff;
            hour_nxt = hour_r + 6'h10;
          end
        end
        epbcd_pkg::PH_HR_O: begin
          if (ge) begin
            rem_nxt  = diff;
            hour_nxt = hour_r + 6'h01;
          end
        end
        epbcd_pkg::PH_MIN_T: begin
          if (ge) begin
            rem_nxt = diff;
            min_nxt = min_r + 7'h10;
          end
        end
        epbcd_pkg::PH_MIN_O: begin
          if (ge) begin
            rem_nxt = diff;
            min_nxt = min_r + 7'h01;
          end
        end
        epbcd_pkg::PH_SEC_T: begin
          if (ge) begin
            rem_nxt = diff;
            sec_nxt = sec_r + 7'h10;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mon_lo  = mon_r - 4'd10;
  assign mon_bcd = (mon_r >= 4'd10) ? {1'b1, mon_lo} : {1'b0, mon_r};

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    cent_r <= cent_nxt;
    yy_r   <= yy_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    sec_r  <= sec_nxt;
    if (cmd.load) begin
      o_cent_r <= cent_r;
      o_yy_r   <= yy_r;
      o_mon_r  <= mon_bcd;
      o_day_r  <= day_r;
      o_hour_r <= hour_r;
      o_min_r  <= min_r;
      // The remainder is below ten here and is the ones digit itself.
      o_sec_r  <= {sec_r[6:4], rem_r[3:0]};
    end
  end

  assign out_century_bcd = o_cent_r;
  assign out_year_bcd    = o_yy_r;
  assign out_month_bcd   = o_mon_r;
  assign out_day_bcd     = o_day_r;
  assign out_hour_bcd    = o_hour_r;
  assign out_minute_bcd  = o_min_r;
  assign out_second_bcd  = o_sec_r;

endmodule

// File: rtl/epoch_seconds_to_bcd_calendar.sv
// Each of nine phases removes whole units one at a time (years since 1970, up to 136; months;
// tens and ones of day, hour and minute; tens of seconds) in a shared 32-bit compare-and-subtract
// unit, and a closing phase loads the result once the output registers are free. One item is in
// work at a time. Reset (rst_n, synchronous, active low) returns the sequencer to idle and drops
// out_valid; payloads are not reset.
module epoch_seconds_to_bcd_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_century_bcd,
  output logic [7:0]  out_year_bcd,
  output logic [4:0]  out_month_bcd,
  output logic [5:0]  out_day_bcd,
  output logic [5:0]  out_hour_bcd,
  output logic [6:0]  out_minute_bcd,
  output logic [6:0]  out_second_bcd
);

  // The controller walks through the year, month and digit phases; in each
  // phase it holds while the datapath reports that the current unit still
  // fits in the remaining seconds, and the datapath subtracts and counts.
  epbcd_pkg::cmd_t    cmd;
  epbcd_pkg::status_t status;

  epbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the remainder, the BCD year counters, the month
  // counter and the digit counters, and registers the finished result so a
  // new transfer can be taken while it waits at the output.
  epbcd_dp u_dp (
    .clk              (clk),
    .in_epoch_seconds (in_epoch_seconds),
    .cmd              (cmd),
    .status           (status),
    .out_century_bcd  (out_century_bcd),
    .out_year_bcd     (out_year_bcd),
    .out_month_bcd    (out_month_bcd),
    .out_day_bcd      (out_day_bcd),
    .out_hour_bcd     (out_hour_bcd),
    .out_minute_bcd   (out_minute_bcd),
    .out_second_bcd   (out_second_bcd)
  );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the epoch-seconds to BCD calendar converter.
`timescale 1ns / 100ps

module tb_top;

  // This pad outlasts the longest conversion, so it outlasts any result in flight.
  localparam int DRAIN_PAD_CYCLES = 250;
  // The slowest run is about 1050 items, each as long as the longest conversion, plus receiver
  // stalls and sender gaps. The limit is several times that.
  localparam int LIMIT_CYCLES     = 3000000;
  localparam int HOLD_CYCLES      = 600;

  localparam int unsigned FIRST_YEAR      = 1970;
  localparam int unsigned SECS_PER_DAY    = 86400;
  localparam int unsigned SECS_PER_HOUR   = 3600;
  localparam int unsigned SECS_PER_MINUTE = 60;
  localparam int unsigned SECS_LEAP_YEAR  = 31622400;
  localparam int unsigned SECS_PLAIN_YEAR = 31536000;

  // One converted date and time, laid out at the widths of the result ports.
  typedef struct packed {
    logic [5:0] century;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } calendar_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [5:0]  out_century_bcd;
  logic [7:0]  out_year_bcd;
  logic [4:0]  out_month_bcd;
  logic [5:0]  out_day_bcd;
  logic [5:0]  out_hour_bcd;
  logic [6:0]  out_minute_bcd;
  logic [6:0]  out_second_bcd;

  // Dates that have been predicted for accepted inputs, oldest first.
  calendar_t expected_dates[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;

  // Receiver behavior: the percentage of cycles with stall high, and a request for a long
  // hold-off that the stall process turns into a cycle count of its own.
  int        stall_pct      = 0;
  bit        hold_req       = 1'b0;
  int        hold_left      = 0;

  epoch_seconds_to_bcd_calendar u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_century_bcd  (out_century_bcd),
    .out_year_bcd     (out_year_bcd),
    .out_month_bcd    (out_month_bcd),
    .out_day_bcd      (out_day_bcd),
    .out_hour_bcd     (out_hour_bcd),
    .out_minute_bcd   (out_minute_bcd),
    .out_second_bcd   (out_second_bcd)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Calendar arithmetic used by the predictor and by the stimulus.
  // ---------------------------------------------------------------------------------------

  // Gregorian rule: every fourth year, but not whole centuries unless divisible by 400.
  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  function automatic int unsigned secs_in_year(input int unsigned yr);
    return is_leap_year(yr) ? SECS_LEAP_YEAR : SECS_PLAIN_YEAR;
  endfunction

  function automatic int unsigned secs_in_month(input int unsigned mon, input bit leap);
    int unsigned days;
    case (mon)
      2:           days = leap ? 29 : 28;
      4, 6, 9, 11: days = 30;
      default:     days = 31;
    endcase
    return days * SECS_PER_DAY;
  endfunction

  // Two BCD digits. Values above 99 encode as zero, although no input can produce one.
  function automatic logic [7:0] to_bcd2(input int unsigned value);
    if (value > 99) begin
      return 8'h00;
    end
    return {4'(value / 10), 4'(value % 10)};
  endfunction

  // Converts seconds since the epoch to the calendar fields that the block should return.
  // Whole years are peeled off first, then whole months, and the rest is split by division.
  function automatic calendar_t predict_calendar(input logic [31:0] secs);
    calendar_t   date;
    int unsigned left;
    int unsigned yr;
    int unsigned mon;
    bit          leap;
    left = secs;
    yr   = FIRST_YEAR;
    while (left >= secs_in_year(yr)) begin
      left -= secs_in_year(yr);
      yr++;
    end
    leap = is_leap_year(yr);
    mon  = 1;
    while (mon < 13 && left >= secs_in_month(mon, leap)) begin
      left -= secs_in_month(mon, leap);
      mon++;
    end
    date.century = 6'(to_bcd2(yr / 100));
    date.year    = to_bcd2(yr % 100);
    date.month   = 5'(to_bcd2(mon));
    date.day     = 6'(to_bcd2(left / SECS_PER_DAY + 1));
    left         = left % SECS_PER_DAY;
    date.hour    = 6'(to_bcd2(left / SECS_PER_HOUR));
    left         = left % SECS_PER_HOUR;
    date.minute  = 7'(to_bcd2(left / SECS_PER_MINUTE));
    date.second  = 7'(to_bcd2(left % SECS_PER_MINUTE));
    return date;
  endfunction

  // Seconds at midnight on January 1st of the given year.
  function automatic longint unsigned secs_at_year_start(input int unsigned yr);
    longint unsigned total;
    total = 0;
    for (int unsigned y = FIRST_YEAR; y < yr; y++) begin
      total += secs_in_year(y);
    end
    return total;
  endfunction

  // Random input time. Most picks cover the whole 32-bit range, which toggles every input
  // bit. The rest cluster around the places where the carry logic is most likely to slip:
  // the first and last stretch of the range, year boundaries and midnight.
  function automatic logic [31:0] pick_epoch();
    longint signed   pick;
    logic     [31:0] secs;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        secs = $urandom;
      end
      6: begin
        secs = $urandom_range(0, 32'h03FF_FFFF);
      end
      7: begin
        secs = 32'hFFFF_FFFF - $urandom_range(0, 32'h03FF_FFFF);
      end
      8: begin
        pick = longint'(secs_at_year_start($urandom_range(1971, 2106)))
             + longint'($urandom_range(0, 2 * SECS_PER_DAY)) - longint'(SECS_PER_DAY);
        secs = (pick > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : 32'(pick);
      end
      default: begin
        secs = $urandom;
        secs = secs - (secs % SECS_PER_DAY);
        if ($urandom_range(0, 1) == 1 && secs <= 32'hFFFF_FFFF - (SECS_PER_DAY - 1)) begin
          secs = secs + SECS_PER_DAY - 1;
        end
      end
    endcase
    return secs;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving. Inputs change only at the falling edge. The DUT samples them at the rising edge.
  // ---------------------------------------------------------------------------------------

  // Offers one time stamp and returns at the falling edge after the transfer, with valid
  // still high. This lets a burst carry on without valid dropping between items.
  task automatic send_epoch(input logic [31:0] secs);
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_dates.push_back(predict_calendar(secs));
    @(negedge clk);
  endtask

  // Drops valid for a gap of the given length. A zero-length gap keeps the burst going.
  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every predicted date has come back from the block.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_dates.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver. The stall pattern is its own: a random percentage set per test, broken by a
  // long hold-off whenever a test asks for one.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each result transfer is checked against the oldest predicted date, one field at a time.
  always @(posedge clk) begin : result_check
    calendar_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: result transfer with no input pending, actual %h %h %h %h %h %h %h",
                 $time, out_century_bcd, out_year_bcd, out_month_bcd, out_day_bcd,
                 out_hour_bcd, out_minute_bcd, out_second_bcd);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("century", 8'(want.century), 8'(out_century_bcd));
        check_field("year",    want.year,        out_year_bcd);
        check_field("month",   8'(want.month),   8'(out_month_bcd));
        check_field("day",     8'(want.day),     8'(out_day_bcd));
        check_field("hour",    8'(want.hour),    8'(out_hour_bcd));
        check_field("minute",  8'(want.minute),  8'(out_minute_bcd));
        check_field("second",  8'(want.second),  8'(out_second_bcd));
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // Hand-picked times: both ends of the input range, alternating bit patterns, leap days,
  // the turn of a century that is a leap year and of one that is not, and the last second
  // of a month or year next to the first second of the next.
  task automatic test_calendar_edges();
    stall_pct = 0;
    send_epoch(32'd0);             // 1970-01-01 00:00:00
    send_epoch(32'hFFFF_FFFF);     // 2106-02-07 06:28:15
    send_epoch(32'h7FFF_FFFF);     // 2038-01-19 03:14:07
    send_epoch(32'h8000_0000);
    send_epoch(32'h5555_5555);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'd2678399);       // last second of January 1970
    send_epoch(32'd2678400);       // February 1st
    send_epoch(32'd68169600);      // 1972-02-29, first leap day
    send_epoch(32'd94694399);      // 1972-12-31 23:59:59
    send_epoch(32'd94694400);      // 1973-01-01
    send_epoch(32'd946684799);     // 1999-12-31 23:59:59
    send_epoch(32'd946684800);     // 2000-01-01, century digits roll
    send_epoch(32'd951782400);     // 2000-02-29, leap by the 400-year rule
    send_epoch(32'd951868800);     // 2000-03-01
    send_epoch(32'd4102444799);    // 2099-12-31 23:59:59
    send_epoch(32'd4102444800);    // 2100-01-01
    send_epoch(32'd4107542399);    // 2100-02-28 23:59:59, no leap day in 2100
    send_epoch(32'd4107542400);    // 2100-03-01
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering. The result
  // register fills, the next item finishes behind it, and the input must then stall.
  task automatic test_output_hold_off();
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (8) send_epoch(pick_epoch());
    wait_for_results();
  endtask

  // The sender goes quiet until the block has delivered everything, then starts again from
  // an idle block.
  task automatic test_drain_and_restart();
    stall_pct = 30;
    repeat (10) send_epoch(pick_epoch());
    wait_for_results();
    repeat (10) send_epoch(pick_epoch());
    wait_for_results();
  endtask

  // Random times sent in bursts of random length with random gaps in between, so that a
  // new item is offered during every phase of the conversion.
  task automatic run_random_traffic(input int count, input int stall_level, input int max_gap);
    int sent;
    int burst;
    stall_pct = stall_level;
    sent      = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (sent < count) begin
          send_epoch(pick_epoch());
          sent++;
        end
      end
      pause_sender($urandom_range(0, max_gap));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_calendar_edges();
    test_output_hold_off();
    test_drain_and_restart();
    run_random_traffic(350, 0, 0);      // back to back with a receiver that never stalls
    run_random_traffic(350, 40, 250);   // gaps long enough to idle the block between items
    run_random_traffic(300, 80, 20);    // heavy stall with short gaps

    wait_for_results();
    repeat (DRAIN_PAD_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
